// ===== src/md5_pkg.sv =====
// Package with MD5 constants, types and helper functions.
`default_nettype none
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned LAST_ROUND = 63;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic put_byte;     // write the input byte and count it
        logic put_pad;      // write the 0x80 marker at the byte position
        logic put_length;   // write the bit count into words 14 and 15
        logic start_block;  // load working words from the chaining words
        logic do_round;     // run one MD5 step
        logic finish_block; // add into chaining words and clear the block
        logic restart;      // return to initial values
    } md5_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       block_full; // byte position is 63 before a write
        logic       pad_spill;  // byte position is 56 or more
        logic       last_round; // round counter at 63
    } md5_stat_t;

    function automatic logic [31:0] step_const(input logic [5:0] i);
        logic [31:0] k;
        begin
            unique case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] step_rot(input logic [3:0] sel);
        logic [4:0] r;
        begin
            unique case (sel)
                4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
                4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
                4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
                4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage
`default_nettype wire

// ===== src/md5_datapath.sv =====
// Datapath: block buffer, bit counter, chaining words and the MD5 step unit.
`default_nettype none
module md5_datapath
    import md5_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire md5_cmd_t    cmd,
    input  wire logic [7:0]  in_byte,
    output md5_stat_t        stat,
    output logic [127:0]     digest
);

    logic [31:0] blk_reg [16];
    logic [31:0] blk_next [16];
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] cnt_reg, cnt_next;
    logic [31:0] h_reg [4];
    logic [31:0] h_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [5:0]  rnd_reg, rnd_next;

    logic [31:0] f_val, sum_val, rot_val;
    logic [3:0]  g_idx;
    logic [4:0]  sh;
    logic [7:0]  wr_byte;

    assign stat.block_full = (pos_reg == 6'd63);
    assign stat.pad_spill  = (pos_reg >= 6'd56);
    assign stat.last_round = (rnd_reg == 6'(LAST_ROUND));

    // Round function and message word index.
    always_comb begin
        unique case (rnd_reg[5:4])
            2'd0: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = rnd_reg[3:0];
            end
            2'd1: begin
                f_val = (d_reg & b_reg) | (~d_reg & c_reg);
                g_idx = 4'(5 * rnd_reg + 1);
            end
            2'd2: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'(3 * rnd_reg + 5);
            end
            default: begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'(7 * rnd_reg);
            end
        endcase
        sh      = step_rot({rnd_reg[5:4], rnd_reg[1:0]});
        sum_val = a_reg + f_val + step_const(rnd_reg) + blk_reg[g_idx];
        rot_val = (sum_val << sh) | (sum_val >> (6'd32 - {1'b0, sh}));
    end

    // Next-state logic for all datapath registers.
    always_comb begin
        for (int i = 0; i < 16; i++) blk_next[i] = blk_reg[i];
        for (int i = 0; i < 4; i++) h_next[i] = h_reg[i];
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        rnd_next = rnd_reg;
        wr_byte  = cmd.put_pad ? PAD_BYTE : in_byte;
        if (cmd.put_byte || cmd.put_pad) begin
            blk_next[pos_reg[5:2]] = blk_reg[pos_reg[5:2]]
                | ({24'd0, wr_byte} << {pos_reg[1:0], 3'd0});
        end
        if (cmd.put_byte) begin
            pos_next = pos_reg + 6'd1;
            cnt_next = cnt_reg + 64'd8;
        end
        if (cmd.put_length) begin
            blk_next[14] = cnt_reg[31:0];
            blk_next[15] = cnt_reg[63:32];
        end
        if (cmd.start_block) begin
            a_next = h_reg[0]; b_next = h_reg[1];
            c_next = h_reg[2]; d_next = h_reg[3];
            rnd_next = 6'd0;
        end
        if (cmd.do_round) begin
            a_next = d_reg;
            d_next = c_reg;
            c_next = b_reg;
            b_next = b_reg + rot_val;
            rnd_next = rnd_reg + 6'd1;
        end
        if (cmd.finish_block) begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            for (int i = 0; i < 16; i++) blk_next[i] = 32'd0;
        end
    end

    // Control-like state is reset; the working words are payload.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            for (int i = 0; i < 16; i++) blk_reg[i] <= 32'd0;
            pos_reg <= 6'd0;
            cnt_reg <= 64'd0;
            h_reg[0] <= IV_A; h_reg[1] <= IV_B;
            h_reg[2] <= IV_C; h_reg[3] <= IV_D;
        end else begin
            for (int i = 0; i < 16; i++) blk_reg[i] <= blk_next[i];
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            for (int i = 0; i < 4; i++) h_reg[i] <= h_next[i];
        end
        if (!aresetn) begin
            rnd_reg <= 6'd0;
        end else begin
            rnd_reg <= rnd_next;
        end
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
    end

    assign digest = {swap32(h_reg[3]), swap32(h_reg[2]),
                     swap32(h_reg[1]), swap32(h_reg[0])};

endmodule
`default_nettype wire

// ===== src/md5_ctrl.sv =====
// Controller state machine sequencing byte intake, padding and block hashing.
`default_nettype none
module md5_ctrl
    import md5_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      in_has_byte,
    input  wire logic      in_last,
    output logic           out_load,
    input  wire logic      out_free,
    input  wire md5_stat_t stat,
    output md5_cmd_t       cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD    = 7'b0000010,
        ST_START  = 7'b0000100,
        ST_ROUND  = 7'b0001000,
        ST_FINISH = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_LEN    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;   // finishing a message
    logic   pad_reg, pad_next;       // pad marker already written
    logic   len_reg, len_next;       // length already written into block

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        pad_next   = pad_reg;
        len_next   = len_reg;
        cmd        = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.put_byte = in_has_byte;
                    final_next   = in_last;
                    pad_next     = 1'b0;
                    len_next     = 1'b0;
                    if (in_has_byte && stat.block_full) begin
                        state_next = ST_START;
                    end else if (in_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.put_pad = 1'b1;
                pad_next    = 1'b1;
                state_next  = stat.pad_spill ? ST_START : ST_LEN;
            end
            ST_LEN: begin
                cmd.put_length = 1'b1;
                len_next       = 1'b1;
                state_next     = ST_START;
            end
            ST_START: begin
                cmd.start_block = 1'b1;
                state_next      = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.do_round = 1'b1;
                if (stat.last_round) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish_block = 1'b1;
                // After a full block the pad lands at position zero; after a
                // spilled pad the length goes into a fresh block.
                priority if (!final_reg)  state_next = ST_IDLE;
                else if (len_reg)         state_next = ST_EMIT;
                else if (!pad_reg)        state_next = ST_PAD;
                else                      state_next = ST_LEN;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    cmd.restart = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            pad_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
            pad_reg   <= pad_next;
            len_reg   <= len_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/md5_message_digest_unit.sv =====
// Top level of the streaming MD5 digest unit.
// Usage:
// The slave channel takes one item per handshake: tdata[7:0] is a message
// byte, tuser[0] says whether that byte is present, tlast ends the message.
// The master channel gives one item per message holding the four digest
// words, each byte-swapped, word 0 lowest, so the usual MD5 string reads from the lowest word up.
// Throughput: a byte item that does not fill a 64-byte block leaves the input
// ready; one that fills it starts the hash, one MD5 step per cycle in a shared
// round unit, while the input stalls. A last item has one or two blocks hashed
// (the final one padded) before the digest is loaded into the output register.
// The output register holds the digest until taken; the next message may
// start as soon as it is loaded. If the receiver stalls with a digest still
// waiting, the next digest waits in the chaining words and the input stalls.
// Reset (aresetn low, synchronous) restores the initial chaining values,
// clears the buffer, the byte count and the output valid flag.
`default_nettype none
module md5_message_digest_unit
    import md5_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tuser,   // has_byte
    input  wire logic         s_tlast,   // last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // digest_word0..digest_word3, lowest first
);

    md5_cmd_t     cmd;
    md5_stat_t    stat;
    logic [127:0] digest;
    logic         out_load, out_free;
    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    md5_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_has_byte(s_tuser), .in_last(s_tlast),
        .out_load(out_load), .out_free(out_free),
        .stat(stat), .cmd(cmd)
    );

    md5_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .in_byte(s_tdata), .stat(stat), .digest(digest)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) m_tdata_reg <= digest;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // A digest is never loaded over one still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free) else $error("digest overwritten");
    // No input is taken while a hash is in flight.
    a_idle_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_round |-> !s_tready) else $error("accept during hash");
    // A pending result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
`endif

endmodule
`default_nettype wire
